### hw/rtl/sorted_list_table_core_macros.svh
// ----------------------------------------------------------------------------
// Sorted list table assertion macros
// Concurrent assertion helpers that compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_TABLE_CORE_MACROS_SVH
`define SORTED_LIST_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define SLT_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SLT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SLT_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define SLT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### hw/rtl/slt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list table package
// Operation codes, cell commands and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

  localparam int unsigned FuncWidth = 3;

  typedef enum logic [FuncWidth-1:0] {
    FN_CLEAR      = 3'd0,
    FN_INS_SORTED = 3'd1,
    FN_INS_HEAD   = 3'd2,
    FN_DEL_FIRST  = 3'd3,
    FN_DEL_ALL    = 3'd4,
    FN_SEARCH     = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    CO_HOLD,
    CO_INS_SORTED,
    CO_INS_HEAD,
    CO_DEL_FIRST
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_DEL_ALL
  } state_e;

  typedef struct packed {
    cell_op_e op;
    logic     valid;
    logic     valid_left;
    logic     sfx_gt;
    logic     sfx_gt_left;
    logic     hit_upto;
  } cell_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/slt_cell.sv
// ----------------------------------------------------------------------------
// Sorted list table cell
// Holds one entry, compares it with the request value and moves data
// to or from its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_cell #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire                         clk_i,
  input  slt_pkg::cell_ctl_t          ctl_i,
  input  wire  [VALUE_WIDTH-1:0]      value_i,
  input  wire  [VALUE_WIDTH-1:0]      left_i,
  input  wire  [VALUE_WIDTH-1:0]      right_i,
  output logic [VALUE_WIDTH-1:0]      entry_o,
  output logic                        gt_o,
  output logic                        eq_o
);

  logic [VALUE_WIDTH-1:0] entry_q;
  logic [VALUE_WIDTH-1:0] entry_d;

  assign entry_o = entry_q;
  assign gt_o    = $signed(entry_q) > $signed(value_i);
  assign eq_o    = entry_q == value_i;

  always_comb begin
    entry_d = entry_q;
    case (ctl_i.op)
      slt_pkg::CO_INS_SORTED: begin
        if (ctl_i.valid_left && ctl_i.sfx_gt_left) begin
          entry_d = left_i;
        end else if ((ctl_i.valid && ctl_i.sfx_gt) ||
                     (!ctl_i.valid && ctl_i.valid_left)) begin
          entry_d = value_i;
        end
      end
      slt_pkg::CO_INS_HEAD: begin
        if (ctl_i.valid_left) begin
          entry_d = left_i;
        end
      end
      slt_pkg::CO_DEL_FIRST: begin
        if (ctl_i.hit_upto) begin
          entry_d = right_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

### hw/rtl/slt_result_q.sv
// ----------------------------------------------------------------------------
// Sorted list table result queue
// Two-entry output queue that decouples the list from a stalled receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_result_q #(
  parameter int unsigned WIDTH = 9
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire  [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  wire              stall_i,
  output logic [WIDTH-1:0] data_o
);

  logic [1:0]       cnt_q;
  logic [1:0]       cnt_d;
  logic [WIDTH-1:0] slot0_q;
  logic [WIDTH-1:0] slot0_d;
  logic [WIDTH-1:0] slot1_q;
  logic [WIDTH-1:0] slot1_d;
  logic             pop;

  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign data_o  = slot0_q;
  assign pop     = valid_o && !stall_i;

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_q;
    if (pop) begin
      slot0_d = slot1_q;
    end
    if (push_i) begin
      if ((cnt_q == 2'd0) || (pop && (cnt_q == 2'd1))) begin
        slot0_d = data_i;
      end else begin
        slot1_d = data_i;
      end
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

`default_nettype wire

### hw/rtl/sorted_list_table_core.sv
// ----------------------------------------------------------------------------
// Sorted list table core
// Fixed-depth list of signed words in ascending order, built from a row of
// cells that shift entries to their neighbors.
// ----------------------------------------------------------------------------
// A request carries func_i and value_i and is taken when in_valid_i is high
// and in_stall_o is low. Each request returns one result with found_o,
// full_error_o, entry_count_o, is_empty_o and is_full_o, offered on
// out_valid_o and taken when out_stall_i is low.
// Clear, both inserts, delete first, search and the unused codes finish in the
// cycle they are taken, so one request per cycle is sustained while the result
// queue has room; the result is registered in the result queue. Delete all
// removes one matching entry per cycle through the cell row, returns its result
// once no match is left, and no request is taken meanwhile.
// A two-entry result queue lets a new request be taken while an earlier result
// still waits; when both slots hold results, in_stall_o rises.
// Reset empties the list and the result queue; entry contents are not cleared
// since only entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_list_table_core_macros.svh"

module sorted_list_table_core #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire  [slt_pkg::FuncWidth-1:0]         func_i,
  input  wire  signed [VALUE_WIDTH-1:0]         value_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic                                  found_o,
  output logic                                  full_error_o,
  output logic [$clog2(DEPTH+1)-1:0]            entry_count_o,
  output logic                                  is_empty_o,
  output logic                                  is_full_o
);

  localparam int unsigned CntWidth = $clog2(DEPTH + 1);
  localparam int unsigned ResWidth = CntWidth + 4;
  localparam logic [CntWidth-1:0] DepthCnt = CntWidth'(DEPTH);

  slt_pkg::state_e    state_q;
  slt_pkg::state_e    state_d;
  logic [CntWidth-1:0] count_q;
  logic [CntWidth-1:0] count_d;
  logic [VALUE_WIDTH-1:0] value_q;

  logic                   accept;
  logic                   active;
  slt_pkg::func_e         cur_func;
  logic [VALUE_WIDTH-1:0] cur_value;
  slt_pkg::cell_op_e      op;
  logic                   push;
  logic                   found;
  logic                   ferr;
  logic                   q_full;
  logic                   list_full;
  logic                   any_hit;
  logic                   multi_hit;

  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] gt;
  logic [DEPTH-1:0] eq;
  logic [DEPTH-1:0] eq_m;
  logic [DEPTH-1:0] ok;
  logic [DEPTH-1:0] sfx;
  logic [DEPTH-1:0] pre;
  logic [VALUE_WIDTH-1:0] entry [DEPTH];
  slt_pkg::cell_ctl_t     ctl [DEPTH];

  logic [ResWidth-1:0] res_in;
  logic [ResWidth-1:0] res_out;

  assign in_stall_o = (state_q != slt_pkg::ST_IDLE) || q_full;
  assign accept     = in_valid_i && !in_stall_o;
  assign active     = accept || (state_q == slt_pkg::ST_DEL_ALL);
  assign cur_func   = (state_q == slt_pkg::ST_DEL_ALL) ? slt_pkg::FN_DEL_ALL
                                                       : slt_pkg::func_e'(func_i);
  assign cur_value  = (state_q == slt_pkg::ST_DEL_ALL) ? value_q : value_i;
  assign list_full  = count_q == DepthCnt;
  assign eq_m       = eq & valid;
  assign ok         = gt | ~valid;
  assign any_hit    = |eq_m;
  assign multi_hit  = |(eq_m & {pre[DEPTH-2:0], 1'b0});

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left;
    logic [VALUE_WIDTH-1:0] right;

    assign valid[i] = count_q > CntWidth'(i);
    assign sfx[i]   = &ok[DEPTH-1:i];
    assign pre[i]   = |eq_m[i:0];

    if (i == 0) begin : g_head
      assign left               = cur_value;
      assign ctl[i].valid_left  = 1'b1;
      assign ctl[i].sfx_gt_left = 1'b0;
    end else begin : g_body
      assign left               = entry[i-1];
      assign ctl[i].valid_left  = valid[i-1];
      assign ctl[i].sfx_gt_left = sfx[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right = entry[i];
    end else begin : g_inner
      assign right = entry[i+1];
    end

    assign ctl[i].op       = op;
    assign ctl[i].valid    = valid[i];
    assign ctl[i].sfx_gt   = sfx[i];
    assign ctl[i].hit_upto = pre[i];

    slt_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl[i]),
      .value_i (cur_value),
      .left_i  (left),
      .right_i (right),
      .entry_o (entry[i]),
      .gt_o    (gt[i]),
      .eq_o    (eq[i])
    );
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    op      = slt_pkg::CO_HOLD;
    push    = 1'b0;
    found   = 1'b0;
    ferr    = 1'b0;
    if (active) begin
      case (cur_func)
        slt_pkg::FN_CLEAR: begin
          count_d = '0;
          push    = 1'b1;
        end
        slt_pkg::FN_INS_SORTED: begin
          push = 1'b1;
          if (list_full) begin
            ferr = 1'b1;
          end else begin
            op      = slt_pkg::CO_INS_SORTED;
            count_d = count_q + CntWidth'(1);
          end
        end
        slt_pkg::FN_INS_HEAD: begin
          push = 1'b1;
          if (list_full) begin
            ferr = 1'b1;
          end else begin
            op      = slt_pkg::CO_INS_HEAD;
            count_d = count_q + CntWidth'(1);
          end
        end
        slt_pkg::FN_DEL_FIRST: begin
          push = 1'b1;
          if (any_hit) begin
            op      = slt_pkg::CO_DEL_FIRST;
            count_d = count_q - CntWidth'(1);
            found   = 1'b1;
          end
        end
        slt_pkg::FN_DEL_ALL: begin
          if (any_hit) begin
            op      = slt_pkg::CO_DEL_FIRST;
            count_d = count_q - CntWidth'(1);
            found   = 1'b1;
          end
          if (any_hit && multi_hit) begin
            state_d = slt_pkg::ST_DEL_ALL;
          end else begin
            state_d = slt_pkg::ST_IDLE;
            push    = 1'b1;
          end
        end
        slt_pkg::FN_SEARCH: begin
          push  = 1'b1;
          found = any_hit;
        end
        default: begin
          push = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slt_pkg::ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q <= value_i;
    end
  end

  assign res_in = {found, ferr, count_d, count_d == '0, count_d == DepthCnt};

  slt_result_q #(
    .WIDTH(ResWidth)
  ) u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res_in),
    .full_o  (q_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (res_out)
  );

  assign found_o       = res_out[ResWidth-1];
  assign full_error_o  = res_out[ResWidth-2];
  assign entry_count_o = res_out[ResWidth-3:2];
  assign is_empty_o    = res_out[1];
  assign is_full_o     = res_out[0];

  `SLT_ASSERT_IMPLIES(a_count_range, clk_i, rst_ni, 1'b1, count_q <= DepthCnt)
  `SLT_ASSERT_IMPLIES(a_del_all_hit, clk_i, rst_ni, state_q == slt_pkg::ST_DEL_ALL, any_hit)
  `SLT_ASSERT_IMPLIES(a_push_room, clk_i, rst_ni, push, !q_full)
  `SLT_ASSERT_NEXT(a_refused_keeps, clk_i, rst_ni, active && ferr, $stable(count_q))

endmodule

`default_nettype wire

### tb/sorted_list_table_core_test.sv
// ----------------------------------------------------------------------------
// Sorted list table core testbench
// Drives requests through a clocked driver fed from a queue of pending
// requests, predicts every status result with a model of the sorted list kept
// here, and checks each result field by field with random idling on both
// sides and two long output hold-offs that fill the block.
// ----------------------------------------------------------------------------
module sorted_list_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned VW    = 32;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  localparam logic [slt_pkg::FuncWidth-1:0] FN_SPARE_A = 3'd6;
  localparam logic [slt_pkg::FuncWidth-1:0] FN_SPARE_B = 3'd7;

  typedef struct {
    logic [slt_pkg::FuncWidth-1:0] fn;
    logic signed [VW-1:0]          val;
    int unsigned                   gap;
  } request_t;

  typedef struct {
    bit          found;
    bit          full_err;
    int unsigned count;
    bit          empty;
    bit          full;
  } status_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                          drv_valid = 1'b0;
  logic [slt_pkg::FuncWidth-1:0] drv_func  = '0;
  logic signed [VW-1:0]          drv_value = '0;
  logic                          rx_stall  = 1'b0;

  logic          in_stall_o;
  logic          out_valid_o;
  logic          found_o;
  logic          full_error_o;
  logic [CW-1:0] entry_count_o;
  logic          is_empty_o;
  logic          is_full_o;

  request_t pending_reqs[$];
  status_t  expected_status[$];

  logic signed [VW-1:0] list_mem [DEPTH];
  int unsigned          list_len = 0;

  int unsigned errors    = 0;
  int unsigned wait_cnt  = 0;
  int unsigned rx_wait   = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_left = 0;
  bit          rx_idle_en = 1'b1;

  sorted_list_table_core #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VW)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (drv_valid),
    .in_stall_o   (in_stall_o),
    .func_i       (drv_func),
    .value_i      (drv_value),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (rx_stall),
    .found_o      (found_o),
    .full_error_o (full_error_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void drop_entry(int unsigned pos);
    for (int unsigned j = pos; j + 1 < list_len; j++) list_mem[j] = list_mem[j + 1];
    list_len--;
  endfunction

  function automatic status_t apply_request(logic [slt_pkg::FuncWidth-1:0] fn,
                                            logic signed [VW-1:0] val);
    status_t     st;
    int unsigned i;
    st = '{default: 0};
    case (fn)
      slt_pkg::FN_CLEAR: list_len = 0;
      slt_pkg::FN_INS_SORTED, slt_pkg::FN_INS_HEAD: begin
        if (list_len >= DEPTH) begin
          st.full_err = 1'b1;
        end else begin
          i = list_len;
          while (i > 0 && (fn == slt_pkg::FN_INS_HEAD || list_mem[i-1] > val)) begin
            list_mem[i] = list_mem[i-1];
            i--;
          end
          list_mem[i] = val;
          list_len++;
        end
      end
      slt_pkg::FN_DEL_FIRST: begin
        for (i = 0; i < list_len; i++) begin
          if (list_mem[i] == val) begin
            drop_entry(i);
            st.found = 1'b1;
            break;
          end
        end
      end
      slt_pkg::FN_DEL_ALL: begin
        i = 0;
        while (i < list_len) begin
          if (list_mem[i] == val) begin
            drop_entry(i);
            st.found = 1'b1;
          end else begin
            i++;
          end
        end
      end
      slt_pkg::FN_SEARCH: begin
        for (i = 0; i < list_len; i++) begin
          if (list_mem[i] == val) begin
            st.found = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    st.count = list_len;
    st.empty = (list_len == 0);
    st.full  = (list_len == DEPTH);
    return st;
  endfunction

  task automatic compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver
    bit       busy;
    request_t req;
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      busy = drv_valid;
      if (drv_valid && !in_stall_o) begin
        expected_status.push_back(apply_request(drv_func, drv_value));
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_reqs.size() > 0 && wait_cnt < pending_reqs[0].gap) begin
          wait_cnt++;
          drv_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req = pending_reqs.pop_front();
          wait_cnt = 0;
          drv_valid <= 1'b1;
          drv_func  <= req.fn;
          drv_value <= req.val;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    rx_idle_en <= ((cycle_cnt / 700) % 3) != 1;
    if (cycle_cnt == 300 || cycle_cnt == 4000) begin
      hold_left <= 80;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    status_t exp_st;
    if (!rst_ni) begin
      rx_stall <= 1'b0;
    end else begin
      if (out_valid_o && !rx_stall) begin
        if (expected_status.size() == 0) begin
          $display("%0t: result with no request outstanding", $time);
          errors++;
        end else begin
          exp_st = expected_status.pop_front();
          compare_field("found", exp_st.found, found_o);
          compare_field("full_error", exp_st.full_err, full_error_o);
          compare_field("entry_count", exp_st.count, entry_count_o);
          compare_field("is_empty", exp_st.empty, is_empty_o);
          compare_field("is_full", exp_st.full, is_full_o);
        end
        rx_wait = rx_idle_en ? $urandom_range(0, 3) : 0;
      end
      if (hold_left > 0) begin
        rx_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        rx_stall <= 1'b1;
      end else begin
        rx_stall <= 1'b0;
      end
    end
  end

  function automatic void queue_request(logic [slt_pkg::FuncWidth-1:0] fn,
                                        logic signed [VW-1:0] val,
                                        int unsigned gap);
    request_t req;
    req.fn  = fn;
    req.val = val;
    req.gap = gap;
    pending_reqs.push_back(req);
  endfunction

  function automatic logic signed [VW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $signed($urandom_range(0, 8)) - 4;
    if (r < 75) return {1'b1, {(VW-1){1'b0}}};
    if (r < 80) return {1'b0, {(VW-1){1'b1}}};
    return $urandom;
  endfunction

  initial begin : stimulus
    int unsigned ins_pct [7] = '{80, 30, 60, 85, 20, 50, 70};
    int unsigned r;
    int unsigned gap;
    logic [slt_pkg::FuncWidth-1:0] fn;
    logic signed [VW-1:0] vmin;
    logic signed [VW-1:0] vmax;
    vmin = {1'b1, {(VW-1){1'b0}}};
    vmax = {1'b0, {(VW-1){1'b1}}};

    queue_request(slt_pkg::FN_SEARCH, 0, 0);
    queue_request(slt_pkg::FN_DEL_FIRST, 5, 0);
    queue_request(slt_pkg::FN_DEL_ALL, 5, 1);
    queue_request(slt_pkg::FN_INS_SORTED, 0, 0);
    queue_request(slt_pkg::FN_INS_SORTED, vmax, 0);
    queue_request(slt_pkg::FN_INS_SORTED, vmin, 2);
    queue_request(slt_pkg::FN_INS_SORTED, -1, 0);
    queue_request(slt_pkg::FN_INS_HEAD, 100, 0);
    queue_request(slt_pkg::FN_INS_SORTED, 7, 0);
    queue_request(slt_pkg::FN_INS_SORTED, 7, 3);
    queue_request(slt_pkg::FN_INS_HEAD, 7, 0);
    queue_request(slt_pkg::FN_INS_SORTED, 7, 0);
    queue_request(slt_pkg::FN_SEARCH, 7, 0);
    queue_request(slt_pkg::FN_SEARCH, 8, 1);
    queue_request(slt_pkg::FN_DEL_ALL, 7, 0);
    queue_request(slt_pkg::FN_SEARCH, 7, 0);
    queue_request(slt_pkg::FN_DEL_FIRST, vmin, 0);
    queue_request(slt_pkg::FN_DEL_FIRST, vmax, 0);
    queue_request(FN_SPARE_A, 100, 0);
    queue_request(FN_SPARE_B, -1, 2);
    queue_request(slt_pkg::FN_DEL_ALL, 100, 0);
    queue_request(slt_pkg::FN_CLEAR, 0, 0);
    queue_request(slt_pkg::FN_SEARCH, -1, 0);

    for (int p = 0; p < 7; p++) begin
      for (int n = 0; n < 200; n++) begin
        r = $urandom_range(0, 99);
        if (r < ins_pct[p]) begin
          fn = ($urandom_range(0, 3) == 0) ? slt_pkg::FN_INS_HEAD : slt_pkg::FN_INS_SORTED;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 2) fn = slt_pkg::FN_CLEAR;
          else if (r < 4) fn = ($urandom_range(0, 1) != 0) ? FN_SPARE_A : FN_SPARE_B;
          else if (r < 40) fn = slt_pkg::FN_DEL_FIRST;
          else if (r < 65) fn = slt_pkg::FN_DEL_ALL;
          else fn = slt_pkg::FN_SEARCH;
        end
        gap = ((p % 3) != 1) ? $urandom_range(0, 3) : 0;
        queue_request(fn, pick_value(), gap);
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() > 0 || drv_valid || expected_status.size() > 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (expected_status.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_status.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[sorted_list_table_core] OK");
    end else begin
      $display("[sorted_list_table_core] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("[sorted_list_table_core] ERROR");
    $finish;
  end

endmodule

### sorted_list_table_core.f
+incdir+hw/rtl
hw/rtl/slt_pkg.sv
hw/rtl/slt_cell.sv
hw/rtl/slt_result_q.sv
hw/rtl/sorted_list_table_core.sv
tb/sorted_list_table_core_test.sv
